### rtl/serial_byte_to_memory_bus_bridge_core_defines.svh
// Assertion macros shared by the bridge RTL.
`ifndef SERIAL_BYTE_TO_MEMORY_BUS_BRIDGE_CORE_DEFINES_SVH
`define SERIAL_BYTE_TO_MEMORY_BUS_BRIDGE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked on every rising clock edge outside reset
`define SBMB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define SBMB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define SBMB_ASSERT(label, clk, rst, prop, msg)
`define SBMB_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

### rtl/sbmb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbmb_pkg;

   // Frame and store geometry
   localparam int MAX_BURST_WORDS = 256;
   localparam int BYTES_PER_WORD  = 4;
   localparam int STORE_WORDS     = MAX_BURST_WORDS;
   localparam int STORE_AW        = $clog2(STORE_WORDS);
   localparam int BYTE_IDX_W      = STORE_AW + 2;

   // Default queue depths
   localparam int OPQ_DEPTH_DEF = 4;
   localparam int RSQ_DEPTH_DEF = 4;

   // Input commands
   localparam logic [1:0] CMD_RX_BYTE   = 2'd0;
   localparam logic [1:0] CMD_READ_DATA = 2'd1;
   localparam logic [1:0] CMD_TX_SLOT   = 2'd2;

   // Result kinds
   localparam logic [1:0] KIND_TX_BYTE   = 2'd0;
   localparam logic [1:0] KIND_READ_REQ  = 2'd1;
   localparam logic [1:0] KIND_WRITE_REQ = 2'd2;

   // Header byte positions
   localparam logic [2:0] HDR_TYPE_STEP  = 3'd0;
   localparam logic [2:0] HDR_ADDR_LAST  = 3'd4;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_READ_WAIT,
      PH_WRITE_COLLECT,
      PH_TRANSMIT
   } phase_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  tx_byte;
      logic [31:0] bus_address;
      logic [31:0] bus_word;
      logic [8:0]  burst_words;
      logic        last;
   } result_type;

   // Work handed from the parser to the executer
   typedef struct packed {
      logic [BYTES_PER_WORD-1:0] we;
      logic [STORE_AW-1:0]       mem_addr;
      logic [31:0]               mem_data;
      logic                      rd;
      logic [1:0]                lane;
      logic                      res_valid;
      result_type                res;
   } op_type;

endpackage

`default_nettype wire

### rtl/sbmb_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
`include "serial_byte_to_memory_bus_bridge_core_defines.svh"

module sbmb_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire logic [WIDTH-1:0]             wr_data,
   output logic                              full,
   input  wire logic                         pop,
   output logic [WIDTH-1:0]                  rd_data,
   output logic                              empty,
   output logic [$clog2(DEPTH+1)-1:0]        count
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             push_acc, pop_acc;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign rd_data  = slot_ff[rd_ptr_ff];
   assign push_acc = push && !full;
   assign pop_acc  = pop && !empty;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_acc) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_acc) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_acc && !pop_acc) begin
         count_in = count_ff + 1'b1;
      end else if (pop_acc && !push_acc) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push_acc) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `SBMB_ASSERT(a_count_bound, clock, reset, count_ff <= CW'(DEPTH), "fifo over depth")
   `SBMB_ASSERT_NEXT(a_count_grow, clock, reset, push_acc && !pop_acc, count_ff == $past(count_ff) + 1'b1, "fifo count lost a push")

endmodule

`default_nettype wire

### rtl/sbmb_front.sv
`timescale 1ns / 1ps
`default_nettype none
`include "serial_byte_to_memory_bus_bridge_core_defines.svh"

module sbmb_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_push,
   input  wire logic [1:0]      req_command,
   input  wire logic [7:0]      req_rx_byte,
   input  wire logic [31:0]     req_read_word,
   input  wire logic            op_full,
   output logic                 op_push,
   output sbmb_pkg::op_type     op
);
   import sbmb_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [2:0]              header_count_ff, header_count_in;
   logic                    is_write_ff, is_write_in;
   logic [31:0]             base_address_ff, base_address_in;
   logic [7:0]              count_m1_ff, count_m1_in;
   logic [8:0]              word_index_ff, word_index_in;
   logic [23:0]             assembly_ff, assembly_in;
   logic [BYTE_IDX_W-1:0]   fill_count_ff, fill_count_in;
   logic [BYTE_IDX_W-1:0]   send_index_ff, send_index_in;

   logic accept;
   logic word_fin;
   logic tx_fin;
   logic hdr_done;

   assign accept   = req_push && !op_full;
   assign word_fin = (word_index_ff == {1'b0, count_m1_ff});
   assign tx_fin   = (send_index_ff == {count_m1_ff, 2'b11});
   assign hdr_done = (header_count_ff > HDR_ADDR_LAST);

   // Parser next state
   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      is_write_in     = is_write_ff;
      base_address_in = base_address_ff;
      count_m1_in     = count_m1_ff;
      word_index_in   = word_index_ff;
      assembly_in     = assembly_ff;
      fill_count_in   = fill_count_ff;
      send_index_in   = send_index_ff;
      if (accept) begin
         case (req_command)
            CMD_RX_BYTE: begin
               case (phase_ff)
                  PH_HEADER: begin
                     if (header_count_ff == HDR_TYPE_STEP) begin
                        is_write_in     = (req_rx_byte != 8'd0);
                        header_count_in = header_count_ff + 1'b1;
                     end else if (!hdr_done) begin
                        base_address_in = {base_address_ff[23:0], req_rx_byte};
                        header_count_in = header_count_ff + 1'b1;
                     end else begin
                        count_m1_in     = req_rx_byte;
                        header_count_in = HDR_TYPE_STEP;
                        word_index_in   = '0;
                        fill_count_in   = '0;
                        send_index_in   = '0;
                        assembly_in     = '0;
                        phase_in        = is_write_ff ? PH_WRITE_COLLECT : PH_READ_WAIT;
                     end
                  end
                  PH_WRITE_COLLECT: begin
                     fill_count_in = fill_count_ff + 1'b1;
                     if (fill_count_ff[1:0] != 2'b11) begin
                        assembly_in = {assembly_ff[15:0], req_rx_byte};
                     end else begin
                        assembly_in   = '0;
                        word_index_in = word_index_ff + 1'b1;
                        if (word_fin) begin
                           phase_in      = PH_TRANSMIT;
                           send_index_in = '0;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            CMD_READ_DATA: begin
               if (phase_ff == PH_READ_WAIT) begin
                  word_index_in = word_index_ff + 1'b1;
                  if (word_fin) begin
                     phase_in      = PH_TRANSMIT;
                     send_index_in = '0;
                  end
               end
            end
            CMD_TX_SLOT: begin
               if (phase_ff == PH_TRANSMIT) begin
                  send_index_in = send_index_ff + 1'b1;
                  if (tx_fin) begin
                     phase_in        = PH_HEADER;
                     header_count_in = HDR_TYPE_STEP;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Work item for the executer
   always_comb begin
      op_push = 1'b0;
      op      = '0;
      if (accept) begin
         case (req_command)
            CMD_RX_BYTE: begin
               if (phase_ff == PH_HEADER && hdr_done && !is_write_ff) begin
                  op_push                 = 1'b1;
                  op.res_valid            = 1'b1;
                  op.res.kind             = KIND_READ_REQ;
                  op.res.bus_address      = base_address_ff;
                  op.res.burst_words      = {1'b0, req_rx_byte} + 9'd1;
               end else if (phase_ff == PH_WRITE_COLLECT) begin
                  op_push     = 1'b1;
                  op.we       = BYTES_PER_WORD'(1) << fill_count_ff[1:0];
                  op.mem_addr = fill_count_ff[BYTE_IDX_W-1:2];
                  op.mem_data = {BYTES_PER_WORD{req_rx_byte}};
                  if (fill_count_ff[1:0] == 2'b11) begin
                     op.res_valid       = 1'b1;
                     op.res.kind        = KIND_WRITE_REQ;
                     op.res.bus_address = base_address_ff + 32'(word_index_ff);
                     op.res.bus_word    = {assembly_ff, req_rx_byte};
                     op.res.last        = word_fin;
                  end
               end
            end
            CMD_READ_DATA: begin
               if (phase_ff == PH_READ_WAIT) begin
                  op_push     = 1'b1;
                  op.we       = '1;
                  op.mem_addr = word_index_ff[STORE_AW-1:0];
                  op.mem_data = req_read_word;
               end
            end
            CMD_TX_SLOT: begin
               if (phase_ff == PH_TRANSMIT) begin
                  op_push      = 1'b1;
                  op.rd        = 1'b1;
                  op.mem_addr  = send_index_ff[BYTE_IDX_W-1:2];
                  op.lane      = send_index_ff[1:0];
                  op.res_valid = 1'b1;
                  op.res.kind  = KIND_TX_BYTE;
                  op.res.last  = tx_fin;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         header_count_ff <= '0;
         is_write_ff     <= 1'b0;
         base_address_ff <= '0;
         count_m1_ff     <= '0;
         word_index_ff   <= '0;
         assembly_ff     <= '0;
         fill_count_ff   <= '0;
         send_index_ff   <= '0;
      end else begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         is_write_ff     <= is_write_in;
         base_address_ff <= base_address_in;
         count_m1_ff     <= count_m1_in;
         word_index_ff   <= word_index_in;
         assembly_ff     <= assembly_in;
         fill_count_ff   <= fill_count_in;
         send_index_ff   <= send_index_in;
      end
   end

   `SBMB_ASSERT(a_hdr_idle, clock, reset, (phase_ff == PH_HEADER) || (header_count_ff == HDR_TYPE_STEP), "header count left over outside header phase")

endmodule

`default_nettype wire

### rtl/sbmb_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "serial_byte_to_memory_bus_bridge_core_defines.svh"

module sbmb_back #(
   parameter int RSQ_DEPTH = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          op_empty,
   input  wire sbmb_pkg::op_type              op,
   output logic                               op_pop,
   input  wire logic [$clog2(RSQ_DEPTH+1)-1:0] rsq_count,
   output logic                               rsq_push,
   output sbmb_pkg::result_type               rsq_data
);
   import sbmb_pkg::*;

   localparam int CW = $clog2(RSQ_DEPTH + 1);

   logic [31:0]  store_mem [STORE_WORDS];
   logic [31:0]  rdata_ff;
   logic         stage_valid_ff, stage_valid_in;
   logic         stage_rd_ff;
   logic [1:0]   stage_lane_ff;
   result_type   stage_res_ff;
   logic [CW:0]  committed;
   logic         room;

   // A result may start only if the response queue can hold it
   assign committed = {1'b0, rsq_count} + (CW + 1)'(stage_valid_ff);
   assign room      = (committed < (CW + 1)'(RSQ_DEPTH));
   assign op_pop    = !op_empty && (!op.res_valid || room);
   assign stage_valid_in = op_pop && op.res_valid;

   // Byte store: byte lane k of a word sits at bits [31-8k -: 8]
   always_ff @(posedge clock) begin
      if (op_pop) begin
         for (int k = 0; k < BYTES_PER_WORD; k++) begin
            if (op.we[k]) begin
               store_mem[op.mem_addr][8*(BYTES_PER_WORD-1-k) +: 8] <=
                  op.mem_data[8*(BYTES_PER_WORD-1-k) +: 8];
            end
         end
         if (op.rd) begin
            rdata_ff <= store_mem[op.mem_addr];
         end
      end
   end

   // Result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (op_pop) begin
         stage_rd_ff   <= op.rd;
         stage_lane_ff <= op.lane;
         stage_res_ff  <= op.res;
      end
   end

   // Transmit bytes take their value from the store read
   always_comb begin
      rsq_push = stage_valid_ff;
      rsq_data = stage_res_ff;
      if (stage_rd_ff) begin
         rsq_data.tx_byte = rdata_ff[{~stage_lane_ff, 3'b000} +: 8];
      end
   end

   `SBMB_ASSERT(a_rsq_room, clock, reset, !rsq_push || (rsq_count < CW'(RSQ_DEPTH)), "response queue overrun")
   `SBMB_ASSERT_NEXT(a_rd_stage, clock, reset, op_pop && op.rd, stage_valid_ff && stage_rd_ff, "store read lost its result")

endmodule

`default_nettype wire

### rtl/serial_byte_to_memory_bus_bridge_core.sv
`timescale 1ns / 1ps
`default_nettype none
`include "serial_byte_to_memory_bus_bridge_core_defines.svh"

// Path: a request's work item is registered in the work queue, its result in
//   the executer's result stage, then in the response queue at the rsp_ ports.
// Throughput: one request per cycle; the parser stalls only when the work queue
//   between parser and executer fills up.
// Reset (synchronous) clears parser state and both queues; the 256 x 32 byte
//   store is not cleared, and every echoed byte is written earlier in its frame.
module serial_byte_to_memory_bus_bridge_core #(
   parameter int OPQ_DEPTH = sbmb_pkg::OPQ_DEPTH_DEF,
   parameter int RSQ_DEPTH = sbmb_pkg::RSQ_DEPTH_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   output logic               full,
   input  wire logic [1:0]    req_command,
   input  wire logic [7:0]    req_rx_byte,
   input  wire logic [31:0]   req_read_word,
   output logic               empty,
   input  wire logic          pop,
   output logic [1:0]         rsp_kind,
   output logic [7:0]         rsp_tx_byte,
   output logic [31:0]        rsp_bus_address,
   output logic [31:0]        rsp_bus_word,
   output logic [8:0]         rsp_burst_words,
   output logic               rsp_last
);
   import sbmb_pkg::*;

   localparam int OPQ_CW = $clog2(OPQ_DEPTH + 1);
   localparam int RSQ_CW = $clog2(RSQ_DEPTH + 1);

   op_type               fr_op;
   logic                 fr_push;
   logic                 opq_full;
   logic [$bits(op_type)-1:0] opq_rd_bits;
   op_type               opq_rd;
   logic                 opq_empty;
   logic [OPQ_CW-1:0]    opq_count;
   logic                 bk_pop;
   logic [RSQ_CW-1:0]    rsq_count;
   logic                 rsq_push;
   result_type           rsq_wr;
   logic [$bits(result_type)-1:0] rsq_rd_bits;
   result_type           rsq_rd;
   logic                 rsq_full;

   // Parser
   sbmb_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (push),
      .req_command   (req_command),
      .req_rx_byte   (req_rx_byte),
      .req_read_word (req_read_word),
      .op_full       (opq_full),
      .op_push       (fr_push),
      .op            (fr_op)
   );

   // Work queue
   sbmb_fifo #(
      .WIDTH ($bits(op_type)),
      .DEPTH (OPQ_DEPTH)
   ) u_opq (
      .clock   (clock),
      .reset   (reset),
      .push    (fr_push),
      .wr_data (fr_op),
      .full    (opq_full),
      .pop     (bk_pop),
      .rd_data (opq_rd_bits),
      .empty   (opq_empty),
      .count   (opq_count)
   );

   assign opq_rd = op_type'(opq_rd_bits);

   // Executer with byte store
   sbmb_back #(
      .RSQ_DEPTH (RSQ_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_empty  (opq_empty),
      .op        (opq_rd),
      .op_pop    (bk_pop),
      .rsq_count (rsq_count),
      .rsq_push  (rsq_push),
      .rsq_data  (rsq_wr)
   );

   // Response queue
   sbmb_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RSQ_DEPTH)
   ) u_rsq (
      .clock   (clock),
      .reset   (reset),
      .push    (rsq_push),
      .wr_data (rsq_wr),
      .full    (rsq_full),
      .pop     (pop),
      .rd_data (rsq_rd_bits),
      .empty   (empty),
      .count   (rsq_count)
   );

   assign rsq_rd = result_type'(rsq_rd_bits);

   // Request side stalls only on a full work queue
   assign full = opq_full;

   assign rsp_kind        = rsq_rd.kind;
   assign rsp_tx_byte     = rsq_rd.tx_byte;
   assign rsp_bus_address = rsq_rd.bus_address;
   assign rsp_bus_word    = rsq_rd.bus_word;
   assign rsp_burst_words = rsq_rd.burst_words;
   assign rsp_last        = rsq_rd.last;

   `SBMB_ASSERT(a_opq_count, clock, reset,
      opq_full == (opq_count == OPQ_CW'(OPQ_DEPTH)), "work queue full flag out of step")
   `SBMB_ASSERT(a_rsq_no_overrun, clock, reset,
      !(rsq_push && rsq_full), "result pushed into full response queue")

endmodule

`default_nettype wire
